// File: rtl/efc_pkg.sv
// Shared types and constants for the fly camera update block.
// Used by efc_ctrl, efc_datapath and the top level; no dependencies.
`default_nettype none
package efc_pkg;

    localparam int TRIG_ITERATIONS   = 16;
    localparam int DIR_FRACTION_BITS = 14;

    localparam logic [2:0] OP_ROTATE   = 3'd0;
    localparam logic [2:0] OP_FORWARD  = 3'd1;
    localparam logic [2:0] OP_BACKWARD = 3'd2;
    localparam logic [2:0] OP_LEFT     = 3'd3;
    localparam logic [2:0] OP_RIGHT    = 3'd4;

    localparam logic [7:0] REG_SENSITIVITY = 8'd0;
    localparam logic [7:0] REG_MOVE_SPEED  = 8'd1;

    localparam int YAW_SPAN    = 57600;
    localparam int YAW_HALF    = 28800;
    localparam int PITCH_LIMIT = 14240;
    localparam int ONE_Q14     = 16384;
    localparam int WRAP_STEPS  = 9;

    localparam logic       SEL_YAW   = 1'b0;
    localparam logic       SEL_PITCH = 1'b1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_WRAP,
        CMD_CINIT,
        CMD_CITER,
        CMD_CSAVE,
        CMD_MULA,
        CMD_MULB,
        CMD_MULC,
        CMD_DIST,
        CMD_VEC,
        CMD_MOVX,
        CMD_MOVY,
        CMD_MOVZ,
        CMD_POSZ,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [4:0] idx;
        logic       sel;
    } t_dp_ctl;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] in_op;
    } t_dp_sts;

    // arctan(2^-i) in units of 1/(160*65536) degree
    function automatic logic [29:0] f_atan(input logic [4:0] i);
        logic [29:0] a;
        unique case (i)
            5'd0:    a = 30'd471859200;
            5'd1:    a = 30'd278554751;
            5'd2:    a = 30'd147180680;
            5'd3:    a = 30'd74711211;
            5'd4:    a = 30'd37500584;
            5'd5:    a = 30'd18768573;
            5'd6:    a = 30'd9386577;
            5'd7:    a = 30'd4693575;
            5'd8:    a = 30'd2346823;
            5'd9:    a = 30'd1173416;
            5'd10:   a = 30'd586709;
            5'd11:   a = 30'd293354;
            5'd12:   a = 30'd146677;
            5'd13:   a = 30'd73339;
            5'd14:   a = 30'd36669;
            5'd15:   a = 30'd18335;
            5'd16:   a = 30'd9167;
            5'd17:   a = 30'd4584;
            5'd18:   a = 30'd2292;
            5'd19:   a = 30'd1146;
            5'd20:   a = 30'd573;
            5'd21:   a = 30'd286;
            5'd22:   a = 30'd143;
            5'd23:   a = 30'd72;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: rtl/euler_fly_camera_update_unit.sv
// Top level of the fly camera update block: sequencer plus datapath.
// Depends on efc_pkg, efc_ctrl and efc_datapath.
//
//   channel | direction | handshake                   | payload
//   input   | in        | i_in_valid / o_in_ready     | opcode, mouse dx/dy, delta time
//   output  | out       | o_out_valid / i_out_ready   | position, front, yaw, pitch
//   config  | in        | i_cfg_valid / o_cfg_ready   | register index, write data
//
// Rotate runs the nine-step yaw wrap and two passes through the shared
// CORDIC iteration, then the multiply steps. Forward and backward run
// the multiply and move steps; left and right add one CORDIC pass.
// Reset is synchronous; no clearing pass. A stalled output holds in its register
// while the next item is taken; the result of that item waits until it is free.
`default_nettype none
module euler_fly_camera_update_unit #(
    parameter int TRIG_ITERATIONS   = efc_pkg::TRIG_ITERATIONS,
    parameter int DIR_FRACTION_BITS = efc_pkg::DIR_FRACTION_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire         [2:0]  i_opcode,
    input  wire  signed [15:0] i_mouse_dx,
    input  wire  signed [15:0] i_mouse_dy,
    input  wire         [15:0] i_delta_time,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic signed [15:0] o_yaw_out,
    output logic signed [14:0] o_pitch_out,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [7:0]  i_cfg_index,
    input  wire         [15:0] i_cfg_data
);

    efc_pkg::t_dp_ctl ctl;
    efc_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    efc_ctrl #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    efc_datapath #(
        .DIR_FRACTION_BITS(DIR_FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_opcode    (i_opcode),
        .i_mouse_dx  (i_mouse_dx),
        .i_mouse_dy  (i_mouse_dy),
        .i_delta_time(i_delta_time),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_dir_x     (o_dir_x),
        .o_dir_y     (o_dir_y),
        .o_dir_z     (o_dir_z),
        .o_yaw_out   (o_yaw_out),
        .o_pitch_out (o_pitch_out)
    );

    // an input transfer starts work, so no second item right after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while busy");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_out <= 15'sd14240 && o_pitch_out >= -15'sd14240))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_yaw_out <= 16'sd28799 && o_yaw_out >= -16'sd28800))
        else $error("yaw out of range");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
                         o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384))
        else $error("front vector out of range");

endmodule
`default_nettype wire

// File: rtl/efc_ctrl.sv
// Sequencer for the fly camera update: steps the datapath through
// wrap, CORDIC, multiply and move phases. Depends on efc_pkg.
`default_nettype none
module efc_ctrl #(
    parameter int TRIG_ITERATIONS = efc_pkg::TRIG_ITERATIONS
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  efc_pkg::t_dp_sts i_sts,
    output efc_pkg::t_dp_ctl o_ctl
);

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_WRAP    = 18'b000000000000000010,
        S_CINIT_Y = 18'b000000000000000100,
        S_ITER_Y  = 18'b000000000000001000,
        S_SAVE_Y  = 18'b000000000000010000,
        S_CINIT_P = 18'b000000000000100000,
        S_ITER_P  = 18'b000000000001000000,
        S_SAVE_P  = 18'b000000000010000000,
        S_MULA    = 18'b000000000100000000,
        S_MULB    = 18'b000000001000000000,
        S_MULC    = 18'b000000010000000000,
        S_DIST    = 18'b000000100000000000,
        S_VEC     = 18'b000001000000000000,
        S_MOVX    = 18'b000010000000000000,
        S_MOVY    = 18'b000100000000000000,
        S_MOVZ    = 18'b001000000000000000,
        S_POSZ    = 18'b010000000000000000,
        S_DONE    = 18'b100000000000000000
    } t_state;

    localparam logic [4:0] ITER_LAST = 5'(TRIG_ITERATIONS - 1);
    localparam logic [4:0] WRAP_TOP  = 5'(efc_pkg::WRAP_STEPS - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_ctl.cmd   = efc_pkg::CMD_NONE;
        o_ctl.idx   = r_cnt;
        o_ctl.sel   = efc_pkg::SEL_YAW;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = efc_pkg::CMD_LOAD;
                    n_state   = S_DONE;
                end
            end
            S_WRAP: begin
                o_ctl.cmd = efc_pkg::CMD_WRAP;
                n_cnt     = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_CINIT_Y;
                end
            end
            S_CINIT_Y: begin
                o_ctl.cmd = efc_pkg::CMD_CINIT;
                n_cnt     = 5'd0;
                n_state   = S_ITER_Y;
            end
            S_ITER_Y: begin
                o_ctl.cmd = efc_pkg::CMD_CITER;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == ITER_LAST) begin
                    n_state = S_SAVE_Y;
                end
            end
            S_SAVE_Y: begin
                o_ctl.cmd = efc_pkg::CMD_CSAVE;
                n_state   = (i_sts.op == efc_pkg::OP_ROTATE) ? S_CINIT_P : S_DIST;
            end
            S_CINIT_P: begin
                o_ctl.cmd = efc_pkg::CMD_CINIT;
                o_ctl.sel = efc_pkg::SEL_PITCH;
                n_cnt     = 5'd0;
                n_state   = S_ITER_P;
            end
            S_ITER_P: begin
                o_ctl.cmd = efc_pkg::CMD_CITER;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == ITER_LAST) begin
                    n_state = S_SAVE_P;
                end
            end
            S_SAVE_P: begin
                o_ctl.cmd = efc_pkg::CMD_CSAVE;
                o_ctl.sel = efc_pkg::SEL_PITCH;
                n_state   = S_MULA;
            end
            S_MULA: begin
                o_ctl.cmd = efc_pkg::CMD_MULA;
                n_state   = S_MULB;
            end
            S_MULB: begin
                o_ctl.cmd = efc_pkg::CMD_MULB;
                n_state   = S_MULC;
            end
            S_MULC: begin
                o_ctl.cmd = efc_pkg::CMD_MULC;
                n_state   = S_DONE;
            end
            S_DIST: begin
                o_ctl.cmd = efc_pkg::CMD_DIST;
                n_state   = S_VEC;
            end
            S_VEC: begin
                o_ctl.cmd = efc_pkg::CMD_VEC;
                n_state   = S_MOVX;
            end
            S_MOVX: begin
                o_ctl.cmd = efc_pkg::CMD_MOVX;
                n_state   = S_MOVY;
            end
            S_MOVY: begin
                o_ctl.cmd = efc_pkg::CMD_MOVY;
                n_state   = S_MOVZ;
            end
            S_MOVZ: begin
                o_ctl.cmd = efc_pkg::CMD_MOVZ;
                n_state   = S_POSZ;
            end
            S_POSZ: begin
                o_ctl.cmd = efc_pkg::CMD_POSZ;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.cmd   = efc_pkg::CMD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // branch on the opcode offered with the input transfer
        if (r_state == S_IDLE && i_in_valid) begin
            n_cnt = WRAP_TOP;
            if (efc_pkg::t_cmd'(o_ctl.cmd) == efc_pkg::CMD_LOAD) begin
                priority if (i_sts.in_op == efc_pkg::OP_ROTATE) begin
                    n_state = S_WRAP;
                end else if (i_sts.in_op == efc_pkg::OP_FORWARD ||
                             i_sts.in_op == efc_pkg::OP_BACKWARD) begin
                    n_state = S_DIST;
                end else if (i_sts.in_op == efc_pkg::OP_LEFT ||
                             i_sts.in_op == efc_pkg::OP_RIGHT) begin
                    n_state = S_CINIT_Y;
                end else begin
                    n_state = S_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: rtl/efc_datapath.sv
// Datapath of the fly camera update: camera state, yaw wrap, shared
// CORDIC iteration, one shared multiplier and output registers. Uses efc_pkg.
`default_nettype none
module efc_datapath #(
    parameter int DIR_FRACTION_BITS = efc_pkg::DIR_FRACTION_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  efc_pkg::t_dp_ctl   i_ctl,
    output efc_pkg::t_dp_sts   o_sts,
    input  wire         [2:0]  i_opcode,
    input  wire  signed [15:0] i_mouse_dx,
    input  wire  signed [15:0] i_mouse_dy,
    input  wire         [15:0] i_delta_time,
    input  wire                i_cfg_we,
    input  wire         [7:0]  i_cfg_index,
    input  wire         [15:0] i_cfg_data,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic signed [15:0] o_yaw_out,
    output logic signed [14:0] o_pitch_out
);

    localparam int W    = DIR_FRACTION_BITS;
    localparam int XW   = W + 3;
    localparam int MAW  = 33;
    localparam int MBW  = (XW > 17) ? XW : 17;
    localparam int PW   = MAW + MBW;
    localparam int RS   = (W > 14) ? W - 14 : 0;
    localparam int LS   = (W < 14) ? 14 - W : 0;
    localparam int HALF_Q = (1 << RS) >> 1;
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam longint GAIN_INIT =
        (GAIN_Q30 + (64'd1 << (29 - W))) >> (30 - W);
    localparam logic signed [33:0] DEG90  = 34'sd943718400;
    localparam logic signed [33:0] DEG180 = 34'sd1887436800;
    localparam logic signed [PW-1:0] SMAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

    function automatic logic signed [15:0] f_q14(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = ((v + PW'(HALF_Q)) >>> RS) <<< LS;
        if (r > PW'(efc_pkg::ONE_Q14)) begin
            r = PW'(efc_pkg::ONE_Q14);
        end
        if (r < -PW'(efc_pkg::ONE_Q14)) begin
            r = -PW'(efc_pkg::ONE_Q14);
        end
        return 16'(r);
    endfunction

    function automatic logic signed [31:0] f_move(input logic signed [31:0] p,
                                                 input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] s;
        s = ((prod + PW'(1 << 21)) >>> 22) + PW'(p);
        if (s > SMAX) begin
            s = SMAX;
        end
        if (s < SMIN) begin
            s = SMIN;
        end
        return 32'(s);
    endfunction

    logic        [7:0]     r_sens;
    logic        [15:0]    r_speed;
    logic        [2:0]     r_op;
    logic        [15:0]    r_dt;
    logic        [24:0]    r_v;
    logic signed [31:0]    r_px, r_py, r_pz;
    logic signed [15:0]    r_fx, r_fy, r_fz;
    logic signed [15:0]    r_yaw;
    logic signed [14:0]    r_pitch;
    logic signed [XW-1:0]  r_x, r_y, r_cy, r_sy, r_cp;
    logic signed [33:0]    r_z;
    logic                  r_neg;
    logic signed [32:0]    r_dist;
    logic signed [15:0]    r_vx, r_vy, r_vz;
    logic signed [PW-1:0]  r_prod;

    logic signed [24:0]    yv, pv;
    logic        [24:0]    cmpv, v_next;
    logic signed [15:0]    ang;
    logic signed [33:0]    z0;
    logic signed [XW-1:0]  xs, ys, xf, yf;
    logic signed [33:0]    at;
    logic signed [MAW-1:0] ma;
    logic signed [MBW-1:0] mb;
    logic signed [PW-1:0]  rw;
    logic signed [15:0]    qs, qc;

    assign o_sts.op    = r_op;
    assign o_sts.in_op = i_opcode;

    always_comb begin
        yv = 25'(r_yaw) + ($signed(i_mouse_dx) * $signed({1'b0, r_sens}));
        pv = 25'(r_pitch) + ($signed(i_mouse_dy) * $signed({1'b0, r_sens}));
        cmpv   = 25'(efc_pkg::YAW_SPAN) << i_ctl.idx[3:0];
        v_next = (r_v >= cmpv) ? r_v - cmpv : r_v;
        ang    = (i_ctl.sel == efc_pkg::SEL_PITCH) ? 16'(r_pitch) : r_yaw;
        z0     = {{2{ang[15]}}, ang, 16'b0};
        xs     = r_x >>> i_ctl.idx;
        ys     = r_y >>> i_ctl.idx;
        at     = $signed({4'b0, efc_pkg::f_atan(i_ctl.idx)});
        xf     = r_neg ? -r_x : r_x;
        yf     = r_neg ? -r_y : r_y;
        rw     = (r_prod + PW'(1 << (W - 1))) >>> W;
        qs     = f_q14(PW'(r_sy));
        qc     = f_q14(PW'(r_cy));
        ma     = '0;
        mb     = '0;
        unique case (i_ctl.cmd)
            efc_pkg::CMD_MULA: begin
                ma = MAW'(r_cy);
                mb = MBW'(r_cp);
            end
            efc_pkg::CMD_MULB: begin
                ma = MAW'(r_sy);
                mb = MBW'(r_cp);
            end
            efc_pkg::CMD_DIST: begin
                ma = $signed({17'b0, r_dt});
                mb = MBW'($signed({1'b0, r_speed}));
            end
            efc_pkg::CMD_MOVX: begin
                ma = r_dist;
                mb = MBW'(r_vx);
            end
            efc_pkg::CMD_MOVY: begin
                ma = r_dist;
                mb = MBW'(r_vy);
            end
            efc_pkg::CMD_MOVZ: begin
                ma = r_dist;
                mb = MBW'(r_vz);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= 8'd16;
            r_speed <= 16'd640;
            r_op    <= efc_pkg::OP_ROTATE;
            r_px    <= 32'sd0;
            r_py    <= 32'sd0;
            r_pz    <= 32'sd196608;
            r_fx    <= 16'sd0;
            r_fy    <= 16'sd0;
            r_fz    <= -16'sd16384;
            r_yaw   <= -16'sd14400;
            r_pitch <= 15'sd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == efc_pkg::REG_SENSITIVITY) begin
                    r_sens <= i_cfg_data[7:0];
                end else if (i_cfg_index == efc_pkg::REG_MOVE_SPEED) begin
                    r_speed <= i_cfg_data;
                end
            end
            unique case (i_ctl.cmd)
                efc_pkg::CMD_LOAD: begin
                    r_op <= i_opcode;
                    r_dt <= i_delta_time;
                    if (i_opcode == efc_pkg::OP_ROTATE) begin
                        // bias by half a span plus whole spans so the wrap works on a positive value
                        r_v <= 25'(yv + 25'(efc_pkg::YAW_HALF + 256 * efc_pkg::YAW_SPAN));
                        if (pv > 25'(efc_pkg::PITCH_LIMIT)) begin
                            r_pitch <= 15'(efc_pkg::PITCH_LIMIT);
                        end else if (pv < -25'(efc_pkg::PITCH_LIMIT)) begin
                            r_pitch <= -15'(efc_pkg::PITCH_LIMIT);
                        end else begin
                            r_pitch <= 15'(pv);
                        end
                    end
                end
                efc_pkg::CMD_WRAP: begin
                    r_v <= v_next;
                    if (i_ctl.idx == 5'd0) begin
                        r_yaw <= 16'($signed({1'b0, v_next}) - 26'(efc_pkg::YAW_HALF));
                    end
                end
                efc_pkg::CMD_CINIT: begin
                    r_x <= XW'(GAIN_INIT);
                    r_y <= '0;
                    priority if (z0 > DEG90) begin
                        r_z   <= z0 - DEG180;
                        r_neg <= 1'b1;
                    end else if (z0 < -DEG90) begin
                        r_z   <= z0 + DEG180;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= z0;
                        r_neg <= 1'b0;
                    end
                end
                efc_pkg::CMD_CITER: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                end
                efc_pkg::CMD_CSAVE: begin
                    if (i_ctl.sel == efc_pkg::SEL_PITCH) begin
                        r_cp <= xf;
                        r_fy <= f_q14(PW'(yf));
                    end else begin
                        r_cy <= xf;
                        r_sy <= yf;
                    end
                end
                efc_pkg::CMD_MULA: begin
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_MULB: begin
                    r_fx   <= f_q14(rw);
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_MULC: begin
                    r_fz <= f_q14(rw);
                end
                efc_pkg::CMD_DIST: begin
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_VEC: begin
                    r_dist <= 33'(r_prod);
                    priority if (r_op == efc_pkg::OP_FORWARD) begin
                        r_vx <= r_fx;
                        r_vy <= r_fy;
                        r_vz <= r_fz;
                    end else if (r_op == efc_pkg::OP_BACKWARD) begin
                        r_vx <= -r_fx;
                        r_vy <= -r_fy;
                        r_vz <= -r_fz;
                    end else if (r_op == efc_pkg::OP_LEFT) begin
                        r_vx <= qs;
                        r_vy <= 16'sd0;
                        r_vz <= -qc;
                    end else begin
                        r_vx <= -qs;
                        r_vy <= 16'sd0;
                        r_vz <= qc;
                    end
                end
                efc_pkg::CMD_MOVX: begin
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_MOVY: begin
                    r_px   <= f_move(r_px, r_prod);
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_MOVZ: begin
                    r_py   <= f_move(r_py, r_prod);
                    r_prod <= ma * mb;
                end
                efc_pkg::CMD_POSZ: begin
                    r_pz <= f_move(r_pz, r_prod);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == efc_pkg::CMD_OUT) begin
            o_pos_x     <= r_px;
            o_pos_y     <= r_py;
            o_pos_z     <= r_pz;
            o_dir_x     <= r_fx;
            o_dir_y     <= r_fy;
            o_dir_z     <= r_fz;
            o_yaw_out   <= r_yaw;
            o_pitch_out <= r_pitch;
        end
    end

endmodule
`default_nettype wire
